/* design/rsgt_pkg.sv */
// rsgt_pkg: request and response payload types, verdict codes and register
// indexes for the rtp sequence gap tracker
// no dependencies
package rsgt_pkg;

   // verdict codes carried in the response
   localparam logic [2:0] VERDICT_ACCEPT  = 3'd0;
   localparam logic [2:0] VERDICT_RESTART = 3'd1;
   localparam logic [2:0] VERDICT_AHEAD   = 3'd2;
   localparam logic [2:0] VERDICT_BEHIND  = 3'd3;
   localparam logic [2:0] VERDICT_OLD     = 3'd4;

   // register indexes (byte address bit 2)
   localparam logic REG_MAX_SEQ_AHEAD    = 1'b0;
   localparam logic REG_RESYNC_THRESHOLD = 1'b1;

   // register reset values
   localparam logic [14:0] MAX_SEQ_AHEAD_RESET    = 15'd10;
   localparam logic [3:0]  RESYNC_THRESHOLD_RESET = 4'd3;

   // largest reported zero fill
   localparam logic [14:0] ZERO_FILL_MAX = 15'h7fff;

   typedef struct packed {
      logic [15:0] seq_number;
      logic [31:0] time_stamp;
      logic [9:0]  sample_count;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         verdict;
      logic [14:0]        zero_fill;
      logic signed [47:0] sample_total;
      logic [31:0]        drop_total;
      logic [31:0]        dupe_total;
      logic [31:0]        packet_total;
   } rsp_payload_type;

endpackage

/* design/rtp_sequence_gap_tracker_unit.sv */
// rtp_sequence_gap_tracker_unit: classifies rtp packet headers against the
// expected sequence and timestamp and keeps wrapping stream counters
// depends on rsgt_pkg
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_stall     req_payload (seq, stamp, count)
//   rsp       out        rsp_valid / rsp_stall     rsp_payload (verdict, fill, totals)
//   csr       in/out     psel penable pwrite pready paddr pwdata / prdata
//
// one request per cycle while req_stall is low; its response, set by the single
// state update done at the accepting clock edge, is registered in the output
// stage; a two-entry output (result register plus skid) lets a request be taken
// while one response waits; req_stall rises only when both entries are full
// synchronous reset clears tracking state, counters and registers to defaults
module rtp_sequence_gap_tracker_unit
   import rsgt_pkg::*;
#(
   parameter int RING_SIZE = 65536
) (
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   // response channel
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   // configuration port
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [2:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   localparam logic [31:0] HALF_RING = 32'(RING_SIZE / 2);

   // configuration registers
   logic [14:0] max_seq_ahead_ff;
   logic [3:0]  resync_threshold_ff;

   // tracking state
   logic        started_ff, started_in;
   logic [3:0]  resync_count_ff, resync_count_in;
   logic [15:0] expected_seq_ff, expected_seq_in;
   logic [31:0] expected_time_ff, expected_time_in;
   logic [47:0] sample_counter_ff, sample_counter_in;
   logic [31:0] drop_counter_ff, drop_counter_in;
   logic [31:0] dupe_counter_ff, dupe_counter_in;
   logic [31:0] packet_counter_ff, packet_counter_in;

   // output stage
   logic            out_valid_ff, skid_valid_ff;
   rsp_payload_type out_data_ff, skid_data_ff;
   rsp_payload_type result_in;

   logic        req_accept, rsp_take;
   logic [15:0] seq_delta;
   logic        out_window, threshold_hit, restart, discard;
   logic [3:0]  resync_inc;
   logic [31:0] base_time, gap, fill_gap;
   logic        gap_old, gap_fill;
   logic [2:0]  verdict;
   logic [14:0] zero_fill;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_payload = out_data_ff;
   assign rsp_take   = out_valid_ff && !rsp_stall;

   // configuration access
   assign pready = 1'b1;

   always_comb begin
      prdata = 32'd0;
      unique case (paddr[2])
         REG_MAX_SEQ_AHEAD:    prdata = {17'd0, max_seq_ahead_ff};
         REG_RESYNC_THRESHOLD: prdata = {28'd0, resync_threshold_ff};
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_seq_ahead_ff    <= MAX_SEQ_AHEAD_RESET;
         resync_threshold_ff <= RESYNC_THRESHOLD_RESET;
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[2])
            REG_MAX_SEQ_AHEAD:    max_seq_ahead_ff    <= pwdata[14:0];
            REG_RESYNC_THRESHOLD: resync_threshold_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // sequence window check
   always_comb begin
      seq_delta     = req_payload.seq_number - expected_seq_ff;
      out_window    = started_ff &&
                      (seq_delta[15] || (seq_delta > {1'b0, max_seq_ahead_ff}));
      resync_inc    = resync_count_ff + 4'd1;
      threshold_hit = resync_inc >= resync_threshold_ff;
      restart       = !started_ff || (out_window && threshold_hit);
      discard       = out_window && !threshold_hit;
   end

   // timestamp gap check
   always_comb begin
      base_time = restart ? req_payload.time_stamp : expected_time_ff;
      gap       = req_payload.time_stamp - base_time;
      gap_old   = gap[31];
      gap_fill  = (gap != 32'd0) && (gap < HALF_RING);
      fill_gap  = gap_fill ? gap : 32'd0;
      zero_fill = (fill_gap > {17'd0, ZERO_FILL_MAX}) ? ZERO_FILL_MAX : fill_gap[14:0];
   end

   // next state and verdict
   always_comb begin
      started_in        = started_ff;
      resync_count_in   = resync_count_ff;
      expected_seq_in   = expected_seq_ff;
      expected_time_in  = expected_time_ff;
      sample_counter_in = sample_counter_ff;
      drop_counter_in   = drop_counter_ff;
      dupe_counter_in   = dupe_counter_ff;
      packet_counter_in = packet_counter_ff + 32'd1;
      verdict           = VERDICT_ACCEPT;
      priority if (discard) begin
         resync_count_in = resync_inc;
         if (seq_delta[15]) begin
            dupe_counter_in = dupe_counter_ff + 32'd1;
            verdict         = VERDICT_BEHIND;
         end else begin
            drop_counter_in = drop_counter_ff + 32'd1;
            verdict         = VERDICT_AHEAD;
         end
      end else begin
         started_in      = 1'b1;
         resync_count_in = 4'd0;
         expected_seq_in = req_payload.seq_number + 16'd1;
         if (restart) begin
            // restart: sample counter cleared to zero, expected time set past the count
            verdict           = VERDICT_RESTART;
            sample_counter_in = 48'd0;
            expected_time_in  = req_payload.time_stamp + 32'(req_payload.sample_count);
         end else if (gap_old) begin
            verdict = VERDICT_OLD;
         end else begin
            sample_counter_in = sample_counter_ff + 48'(fill_gap)
                                + 48'(req_payload.sample_count);
            expected_time_in  = req_payload.time_stamp + 32'(req_payload.sample_count);
         end
      end
   end

   // response built from the updated state
   always_comb begin
      result_in.verdict      = verdict;
      result_in.zero_fill    = (discard || restart || gap_old) ? 15'd0 : zero_fill;
      result_in.sample_total = sample_counter_in;
      result_in.drop_total   = drop_counter_in;
      result_in.dupe_total   = dupe_counter_in;
      result_in.packet_total = packet_counter_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff        <= 1'b0;
         resync_count_ff   <= 4'd0;
         expected_seq_ff   <= 16'd0;
         expected_time_ff  <= 32'd0;
         sample_counter_ff <= 48'd0;
         drop_counter_ff   <= 32'd0;
         dupe_counter_ff   <= 32'd0;
         packet_counter_ff <= 32'd0;
      end else if (req_accept) begin
         started_ff        <= started_in;
         resync_count_ff   <= resync_count_in;
         expected_seq_ff   <= expected_seq_in;
         expected_time_ff  <= expected_time_in;
         sample_counter_ff <= sample_counter_in;
         drop_counter_ff   <= drop_counter_in;
         dupe_counter_ff   <= dupe_counter_in;
         packet_counter_ff <= packet_counter_in;
      end
   end

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (!out_valid_ff || rsp_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (req_accept) begin
         if (!out_valid_ff || rsp_take) begin
            out_data_ff <= result_in;
         end else begin
            skid_data_ff <= result_in;
         end
      end
   end

   // checks
   skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a response in the output register");

   accept_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted request left no response");

   packet_count_steps: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (packet_counter_ff == $past(packet_counter_ff) + 32'd1))
      else $error("packet counter did not advance on request");

   discard_no_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.verdict == VERDICT_AHEAD ||
                     rsp_payload.verdict == VERDICT_BEHIND ||
                     rsp_payload.verdict == VERDICT_OLD))
      |-> (rsp_payload.zero_fill == 15'd0))
      else $error("discarded request reported zero fill");

   restart_zero_samples: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.verdict == VERDICT_RESTART)
      |-> (rsp_payload.sample_total == 48'sd0))
      else $error("stream restart did not clear the sample total");

endmodule
